/* hw/rtl/triangle_unit_normal_unit_assert.svh */
// Assertion macros for the triangle normal RTL.
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TUN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TUN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tun_pkg.sv */
// Shared constants, types and the square root step function of the triangle normal pipeline.
package tun_pkg;

   localparam int COORD_BITS_DEFAULT = 20;
   localparam int R_BITS      = 31;             // normalized component magnitude
   localparam int S_BITS      = 64;             // sum of squares / root working width
   localparam int LEN_BITS    = 32;             // integer root
   localparam int Q_BITS      = 16;             // quotient magnitude
   localparam int NUM_BITS    = R_BITS + Q_BITS; // dividend width
   localparam int SQRT_STAGES = 16;
   localparam int SQRT_STEPS  = 2;
   localparam int DIV_STAGES  = 8;
   localparam int DIV_STEPS   = 2;
   localparam int FRONT_STAGES = 9;

   localparam logic [Q_BITS-1:0] Q_POS_MAX = 16'd32767;
   localparam logic [Q_BITS:0]   Q_NEG_MAX = 17'd32768;

   typedef struct packed {
      logic [S_BITS-1:0] v;
      logic [S_BITS-1:0] res;
   } root_type;

   typedef struct packed {
      logic [2:0][R_BITS-1:0] r;
      logic [2:0]             neg;
      logic                   degen;
   } carry_type;

   // One digit of the bitwise integer square root; k counts from 0.
   function automatic root_type root_step(root_type x, int unsigned k);
      logic [S_BITS-1:0] bit_val;
      logic [S_BITS-1:0] trial;
      root_type          y;
      bit_val = S_BITS'(1) << (S_BITS - 2 - 2 * k);
      trial   = x.res + bit_val;
      if (x.v >= trial) begin
         y.v   = x.v - trial;
         y.res = (x.res >> 1) + bit_val;
      end else begin
         y.v   = x.v;
         y.res = x.res >> 1;
      end
      return y;
   endfunction

endpackage

/* hw/rtl/tun_div_lane.sv */
// Pipelined restoring divider for one normal component, two quotient bits per stage.
module tun_div_lane (
   input  logic                          clock,
   input  logic [tun_pkg::DIV_STAGES-1:0] en,
   input  logic [tun_pkg::NUM_BITS-1:0]  num_in,
   input  logic [tun_pkg::LEN_BITS-1:0]  den_in,
   output logic [tun_pkg::Q_BITS-1:0]    quo_out
);
   import tun_pkg::*;

   logic [NUM_BITS-1:0] rem_ff [DIV_STAGES];
   logic [NUM_BITS-1:0] rem_in [DIV_STAGES];
   logic [Q_BITS-1:0]   q_ff   [DIV_STAGES];
   logic [Q_BITS-1:0]   q_in   [DIV_STAGES];
   logic [LEN_BITS-1:0] den_ff [DIV_STAGES];
   logic [LEN_BITS-1:0] den_in_s [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [NUM_BITS-1:0] rem_src;
      logic [Q_BITS-1:0]   q_src;
      if (s == 0) begin : g_first
         assign rem_src     = num_in;
         assign q_src       = '0;
         assign den_in_s[s] = den_in;
      end else begin : g_next
         assign rem_src     = rem_ff[s-1];
         assign q_src       = q_ff[s-1];
         assign den_in_s[s] = den_ff[s-1];
      end

      always_comb begin
         logic [NUM_BITS-1:0] rem;
         logic [Q_BITS-1:0]   q;
         logic [NUM_BITS-1:0] dsh;
         rem = rem_src;
         q   = q_src;
         for (int j = 0; j < DIV_STEPS; j++) begin
            dsh = NUM_BITS'(den_in_s[s]) << (Q_BITS - 1 - (DIV_STEPS * s + j));
            if (rem >= dsh) begin
               rem = rem - dsh;
               q[Q_BITS - 1 - (DIV_STEPS * s + j)] = 1'b1;
            end
         end
         rem_in[s] = rem;
         q_in[s]   = q;
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            den_ff[s] <= den_in_s[s];
         end
      end
   end

   assign quo_out = q_ff[DIV_STAGES-1];

endmodule

/* hw/rtl/triangle_unit_normal_unit.sv */
// Top level of the triangle unit normal pipeline.
//
// Input channel req_*: one triangle per transaction, nine vertex coordinates
// packed in req_tdata. Result channel rsp_*: the unit normal in Q1.15 in
// rsp_tdata and the degenerate flag in rsp_tuser. Configuration: csr_we with
// csr_wdata writes the degenerate length limit; its square is registered at
// the same edge.
//
// Throughput: one triangle per cycle unless rsp_tready holds the pipe. Depth: 35
// register stages, set by the 32-digit square root (16 stages, two digits each)
// and the 16-bit quotient divider (8 stages, two bits each), behind nine front
// stages for edges, cross product, magnitude, limit test, normalizing shift and
// sum of squares, one divider setup stage and one output register.
//
// Every stage carries a valid bit and takes new data when it is empty or when
// the stage after it moves, so bubbles collapse and a stalled receiver only
// backs up the full stages; req_tready drops once the whole pipe is full and rsp_tready is low.
// Reset clears all valid bits and the limit to zero; outside reset no transaction is lost.
`include "triangle_unit_normal_unit_assert.svh"

module triangle_unit_normal_unit #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ax, ay, az, bx, by_coord, bz, cx, cy, cz from bit 0 up, zero padded
   input  logic [((9*COORD_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // nx, ny, nz from bit 0 up
   output logic [3*tun_pkg::Q_BITS-1:0]        rsp_tdata,
   // degenerate
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_we,
   input  logic [31:0]                         csr_wdata
);
   import tun_pkg::*;

   localparam int EW  = COORD_BITS + 1;
   localparam int PW  = 2 * EW;
   localparam int MW  = PW - 1;
   localparam int BLW = $clog2(MW + 1);

   localparam int ST_SUM   = FRONT_STAGES - 1;
   localparam int ST_ROOT0 = FRONT_STAGES;
   localparam int ST_SETUP = ST_ROOT0 + SQRT_STAGES;
   localparam int ST_DIV0  = ST_SETUP + 1;
   localparam int ST_OUT   = ST_DIV0 + DIV_STAGES;
   localparam int NS       = ST_OUT + 1;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   logic [63:0] limit_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_sq_ff <= '0;
      end else if (csr_we) begin
         limit_sq_ff <= 64'(csr_wdata) * 64'(csr_wdata);
      end
   end

   // advance a stage when empty or when its successor advances
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // stage 0: edges
   logic signed [EW-1:0] e_ff [6];
   logic signed [EW-1:0] e_in [6];
   always_comb begin
      logic signed [COORD_BITS-1:0] v [9];
      for (int i = 0; i < 9; i++) v[i] = req_tdata[i*COORD_BITS +: COORD_BITS];
      for (int i = 0; i < 3; i++) begin
         e_in[i]   = EW'(v[3+i]) - EW'(v[i]);
         e_in[3+i] = EW'(v[6+i]) - EW'(v[i]);
      end
   end

   // stage 1: products
   logic signed [PW-1:0] p_ff [6];
   logic signed [PW-1:0] p_in [6];
   always_comb begin
      p_in[0] = e_ff[1] * e_ff[5];
      p_in[1] = e_ff[2] * e_ff[4];
      p_in[2] = e_ff[2] * e_ff[3];
      p_in[3] = e_ff[0] * e_ff[5];
      p_in[4] = e_ff[0] * e_ff[4];
      p_in[5] = e_ff[1] * e_ff[3];
   end

   // stage 2: cross product
   logic signed [PW-1:0] c_ff [3];
   logic signed [PW-1:0] c_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) c_in[i] = p_ff[2*i] - p_ff[2*i+1];
   end

   // stage 3: magnitude and sign
   logic [MW-1:0] m_ff [3];
   logic [MW-1:0] m_in [3];
   logic [2:0]    neg3_ff;
   logic [2:0]    neg3_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg3_in[i] = c_ff[i][PW-1];
         m_in[i]    = neg3_in[i] ? MW'(-c_ff[i]) : MW'(c_ff[i]);
      end
   end

   // stage 4: squares for the limit test, combined bit pattern for the shift
   logic [63:0]   sq_ff [3];
   logic [63:0]   sq_in [3];
   logic          small_ff;
   logic          small_in;
   logic [MW-1:0] orv_ff;
   logic [MW-1:0] orv_in;
   logic [MW-1:0] m4_ff [3];
   logic [2:0]    neg4_ff;
   always_comb begin
      logic [31:0] lo;
      small_in = 1'b1;
      orv_in   = '0;
      for (int i = 0; i < 3; i++) begin
         lo       = 32'(m_ff[i]);
         sq_in[i] = lo * lo;
         if ((m_ff[i] >> 32) != '0) small_in = 1'b0;
         orv_in   = orv_in | m_ff[i];
      end
   end

   // stage 5: limit compare and bit length
   logic           degen5_ff;
   logic           degen5_in;
   logic [BLW-1:0] bl_ff;
   logic [BLW-1:0] bl_in;
   logic [MW-1:0]  m5_ff [3];
   logic [2:0]     neg5_ff;
   always_comb begin
      logic [65:0] ssum;
      ssum      = 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
      degen5_in = small_ff && (ssum <= {2'b00, limit_sq_ff});
      bl_in     = '0;
      for (int i = 0; i < MW; i++) begin
         if (orv_ff[i]) bl_in = BLW'(i + 1);
      end
   end

   // stage 6: common normalizing shift to 31 significant bits
   carry_type c6_in;
   carry_type c6_ff;
   always_comb begin
      logic [MW+R_BITS-1:0] wide;
      for (int i = 0; i < 3; i++) begin
         wide        = {m5_ff[i], {R_BITS{1'b0}}} >> bl_ff;
         c6_in.r[i]  = wide[R_BITS-1:0];
      end
      c6_in.neg   = neg5_ff;
      c6_in.degen = degen5_ff;
   end

   // stage 7: squares of the shifted magnitudes
   logic [2*R_BITS-1:0] rsq_ff [3];
   logic [2*R_BITS-1:0] rsq_in [3];
   carry_type           c7_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) rsq_in[i] = c6_ff.r[i] * c6_ff.r[i];
   end

   // stage 8: sum of squares
   logic [S_BITS-1:0] s_ff;
   logic [S_BITS-1:0] s_in;
   carry_type         c8_ff;
   assign s_in = S_BITS'(rsq_ff[0]) + S_BITS'(rsq_ff[1]) + S_BITS'(rsq_ff[2]);

   always_ff @(posedge clock) begin
      if (en[0]) e_ff <= e_in;
      if (en[1]) p_ff <= p_in;
      if (en[2]) c_ff <= c_in;
      if (en[3]) begin
         m_ff    <= m_in;
         neg3_ff <= neg3_in;
      end
      if (en[4]) begin
         sq_ff    <= sq_in;
         small_ff <= small_in;
         orv_ff   <= orv_in;
         m4_ff    <= m_ff;
         neg4_ff  <= neg3_ff;
      end
      if (en[5]) begin
         degen5_ff <= degen5_in;
         bl_ff     <= bl_in;
         m5_ff     <= m4_ff;
         neg5_ff   <= neg4_ff;
      end
      if (en[6]) c6_ff <= c6_in;
      if (en[7]) begin
         rsq_ff <= rsq_in;
         c7_ff  <= c6_ff;
      end
      if (en[ST_SUM]) begin
         s_ff  <= s_in;
         c8_ff <= c7_ff;
      end
   end

   // square root stages
   root_type  root_ff [SQRT_STAGES];
   root_type  root_in [SQRT_STAGES];
   carry_type rc_ff   [SQRT_STAGES];
   carry_type rc_in   [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_root
      root_type src;
      if (g == 0) begin : g_first
         assign src.v   = s_ff;
         assign src.res = '0;
         assign rc_in[g] = c8_ff;
      end else begin : g_next
         assign src      = root_ff[g-1];
         assign rc_in[g] = rc_ff[g-1];
      end

      always_comb begin
         root_type x;
         x = src;
         for (int j = 0; j < SQRT_STEPS; j++) begin
            x = root_step(x, SQRT_STEPS * g + j);
         end
         root_in[g] = x;
      end

      always_ff @(posedge clock) begin
         if (en[ST_ROOT0 + g]) begin
            root_ff[g] <= root_in[g];
            rc_ff[g]   <= rc_in[g];
         end
      end
   end

   // divider setup: rounded dividend per component
   logic [NUM_BITS-1:0] num_ff [3];
   logic [NUM_BITS-1:0] num_in [3];
   logic [LEN_BITS-1:0] den_ff;
   logic [LEN_BITS-1:0] den_in;
   logic [2:0]          negd_ff;
   logic                degend_ff;
   always_comb begin
      logic [LEN_BITS-1:0] len;
      len    = LEN_BITS'(root_ff[SQRT_STAGES-1].res);
      den_in = (len == '0) ? LEN_BITS'(1) : len;
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUM_BITS'(rc_ff[SQRT_STAGES-1].r[i]) << Q_BITS - 1)
                   + NUM_BITS'(den_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SETUP]) begin
         num_ff    <= num_in;
         den_ff    <= den_in;
         negd_ff   <= rc_ff[SQRT_STAGES-1].neg;
         degend_ff <= rc_ff[SQRT_STAGES-1].degen;
      end
   end

   logic [Q_BITS-1:0] quo [3];
   for (genvar i = 0; i < 3; i++) begin : g_lane
      tun_div_lane u_lane (
         .clock   (clock),
         .en      (en[ST_DIV0 +: DIV_STAGES]),
         .num_in  (num_ff[i]),
         .den_in  (den_ff),
         .quo_out (quo[i])
      );
   end

   // sign and degenerate flag ride alongside the divider
   logic [2:0] dneg_ff   [DIV_STAGES];
   logic       ddegen_ff [DIV_STAGES];
   always_ff @(posedge clock) begin
      if (en[ST_DIV0]) begin
         dneg_ff[0]   <= negd_ff;
         ddegen_ff[0] <= degend_ff;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         if (en[ST_DIV0 + s]) begin
            dneg_ff[s]   <= dneg_ff[s-1];
            ddegen_ff[s] <= ddegen_ff[s-1];
         end
      end
   end

   // output register: saturate, apply sign, zero a degenerate face
   logic [3*Q_BITS-1:0] out_ff;
   logic [3*Q_BITS-1:0] out_in;
   logic                odegen_ff;
   always_comb begin
      logic [Q_BITS:0] q;
      logic [Q_BITS:0] qs;
      for (int i = 0; i < 3; i++) begin
         q = {1'b0, quo[i]};
         if (dneg_ff[DIV_STAGES-1][i]) begin
            qs = (q > Q_NEG_MAX) ? Q_NEG_MAX : q;
            out_in[i*Q_BITS +: Q_BITS] = Q_BITS'((Q_BITS+1)'(0) - qs);
         end else begin
            qs = (q > {1'b0, Q_POS_MAX}) ? {1'b0, Q_POS_MAX} : q;
            out_in[i*Q_BITS +: Q_BITS] = qs[Q_BITS-1:0];
         end
      end
      if (ddegen_ff[DIV_STAGES-1]) out_in = '0;
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_ff    <= out_in;
         odegen_ff <= ddegen_ff[DIV_STAGES-1];
      end
   end

   assign rsp_tvalid   = valid_ff[ST_OUT];
   assign rsp_tdata    = out_ff;
   assign rsp_tuser[0] = odegen_ff;

   `TUN_ASSERT_NEXT(a_accept_loads, clock, reset, req_tvalid && req_tready, valid_ff[0], "accepted transaction did not enter the pipe")
   `TUN_ASSERT_NOW(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "degenerate face with nonzero normal")
   `TUN_ASSERT_NOW(a_normal_nonzero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata != '0, "regular face with zero normal")
   `TUN_ASSERT_NOW(a_root_fits, clock, reset, valid_ff[ST_SETUP-1], root_ff[SQRT_STAGES-1].res[S_BITS-1:LEN_BITS] == '0, "square root wider than its length field")

endmodule
